[rtl/cesu_pkg.sv]
package cesu_pkg;

   localparam logic [7:0]  LEAD1_MAX    = 8'h7F;
   localparam logic [7:0]  LEAD2_MAX    = 8'hDF;
   localparam logic [7:0]  LEAD3_MAX    = 8'hEF;
   localparam logic [7:0]  LEAD4_MARK   = 8'hF0;
   localparam logic [7:0]  CONT_MARK    = 8'h80;
   localparam logic [15:0] HIGH_SUR_MIN = 16'hD800;
   localparam logic [15:0] HIGH_SUR_MAX = 16'hDBFF;
   localparam logic [15:0] LOW_SUR_MIN  = 16'hDC00;
   localparam logic [15:0] LOW_SUR_MAX  = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE    = 21'h10000;

   localparam int BURST_MAX = 6;
   localparam int COUNT_W   = 3;
   localparam logic [COUNT_W-1:0] FLUSH_LEN = 3'd3;

   typedef struct packed {
      logic [8*BURST_MAX-1:0] bytes;
      logic [COUNT_W-1:0]     count;
   } burst_type;

   function automatic logic [15:0] unit_of(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2);
      return {b0[3:0], b1[5:0], b2[5:0]};
   endfunction

   // first byte of the three ends up in the lowest bits
   function automatic logic [23:0] emit_order(input logic [23:0] raw);
      return {raw[7:0], raw[15:8], raw[23:16]};
   endfunction

endpackage

[rtl/cesu8_to_utf8_converter.sv]
// cesu-8 to utf-8 stream converter
// req channel: one cesu-8 byte per transaction in req_tdata, req_tlast on the
// final byte of a string. rsp channel: utf-8 bytes in rsp_tdata, rsp_tlast on
// the final byte produced by one input transaction.
// an input byte is decoded in the cycle it is accepted; its output bytes (zero
// to six) appear from the next cycle, one per cycle while rsp_tready is high.
// a byte that yields one output sustains one transaction per cycle while
// rsp_tready is high; a byte yielding more holds req_tready low until the last
// is taken from the single burst register, which shifts out one byte per cycle.
// a high surrogate yields nothing until the next sequence decides whether it
// pairs; an unpaired one is sent raw ahead of that sequence or at end of string.
// the final byte of a string clears all decode state afterwards.
// reset clears decode state and empties the output register; no clearing pass.
// when the receiver stalls the current byte is held and input is refused, also
// while the burst's last byte is waiting.
module cesu8_to_utf8_converter
   import cesu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte [7:0]
   input  logic       req_tlast,   // end_of_string
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte [7:0]
   output logic       rsp_tlast    // last_out
);

   burst_type burst;
   logic      accept;

   assign accept = req_tvalid && req_tready;

   cesu_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_accept (accept),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .burst     (burst)
   );

   cesu_burst u_burst (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .burst     (burst),
      .can_load  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

[rtl/cesu_decode.sv]
module cesu_decode
   import cesu_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_accept,
   input  logic [7:0] in_byte,
   input  logic      in_last,
   output burst_type burst
);

   logic [1:0]  pass_left_ff, pass_left_in;
   logic [1:0]  gather_count_ff, gather_count_in;
   logic [15:0] gather_bytes_ff, gather_bytes_in;
   logic        held_valid_ff, held_valid_in;
   logic [23:0] held_bytes_ff, held_bytes_in;

   logic [15:0] triple_unit;
   logic [15:0] held_unit;
   logic [20:0] merged;
   logic        pre_flush;
   logic        post_flush;
   logic [31:0] body;
   logic [2:0]  body_n;
   logic [79:0] acc;

   always_comb begin
      pass_left_in    = pass_left_ff;
      gather_count_in = gather_count_ff;
      gather_bytes_in = gather_bytes_ff;
      held_valid_in   = held_valid_ff;
      held_bytes_in   = held_bytes_ff;
      pre_flush       = 1'b0;
      body            = '0;
      body_n          = '0;

      triple_unit = unit_of(gather_bytes_ff[15:8], gather_bytes_ff[7:0], in_byte);
      held_unit   = unit_of(held_bytes_ff[23:16], held_bytes_ff[15:8], held_bytes_ff[7:0]);
      merged      = SUPP_BASE + {1'b0, held_unit[9:0], triple_unit[9:0]};

      if (pass_left_ff != 2'd0) begin
         body         = {24'd0, in_byte};
         body_n       = 3'd1;
         pass_left_in = pass_left_ff - 2'd1;
      end else if (gather_count_ff == 2'd1) begin
         gather_bytes_in = {gather_bytes_ff[15:8], in_byte};
         gather_count_in = 2'd2;
         if (in_last) begin
            pre_flush     = held_valid_ff;
            held_valid_in = 1'b0;
            body          = {16'd0, in_byte, gather_bytes_ff[15:8]};
            body_n        = 3'd2;
         end
      end else if (gather_count_ff != 2'd0) begin
         gather_count_in = 2'd0;
         if (held_valid_ff && (triple_unit inside {[LOW_SUR_MIN:LOW_SUR_MAX]})) begin
            body = {CONT_MARK | {2'b00, merged[5:0]},
                    CONT_MARK | {2'b00, merged[11:6]},
                    CONT_MARK | {2'b00, merged[17:12]},
                    LEAD4_MARK | {5'd0, merged[20:18]}};
            body_n        = 3'd4;
            held_valid_in = 1'b0;
         end else begin
            pre_flush     = held_valid_ff;
            held_valid_in = 1'b0;
            if (triple_unit inside {[HIGH_SUR_MIN:HIGH_SUR_MAX]}) begin
               held_bytes_in = {gather_bytes_ff, in_byte};
               held_valid_in = 1'b1;
            end else begin
               body   = {8'd0, in_byte, gather_bytes_ff[7:0], gather_bytes_ff[15:8]};
               body_n = 3'd3;
            end
         end
      end else if (in_byte <= LEAD1_MAX) begin
         pre_flush     = held_valid_ff;
         held_valid_in = 1'b0;
         body          = {24'd0, in_byte};
         body_n        = 3'd1;
      end else if (in_byte <= LEAD2_MAX) begin
         pre_flush     = held_valid_ff;
         held_valid_in = 1'b0;
         body          = {24'd0, in_byte};
         body_n        = 3'd1;
         pass_left_in  = 2'd1;
      end else if (in_byte <= LEAD3_MAX) begin
         gather_bytes_in = {in_byte, 8'd0};
         gather_count_in = 2'd1;
         if (in_last) begin
            pre_flush     = held_valid_ff;
            held_valid_in = 1'b0;
            body          = {24'd0, in_byte};
            body_n        = 3'd1;
         end
      end else begin
         pre_flush     = held_valid_ff;
         held_valid_in = 1'b0;
         body          = {24'd0, in_byte};
         body_n        = 3'd1;
         pass_left_in  = 2'd3;
      end

      post_flush = in_last && held_valid_in;

      // trailing flush, then body, then leading flush, each pushed up past the next
      acc = post_flush ? {56'd0, emit_order(held_bytes_in)} : '0;
      acc = (acc << {body_n, 3'b000}) | {48'd0, body};
      if (pre_flush) begin
         acc = (acc << 24) | {56'd0, emit_order(held_bytes_ff)};
      end

      burst.bytes = acc[8*BURST_MAX-1:0];
      burst.count = (pre_flush ? FLUSH_LEN : '0) + body_n + (post_flush ? FLUSH_LEN : '0);

      if (in_last) begin
         pass_left_in    = '0;
         gather_count_in = '0;
         gather_bytes_in = '0;
         held_valid_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_left_ff    <= '0;
         gather_count_ff <= '0;
         gather_bytes_ff <= '0;
         held_valid_ff   <= 1'b0;
      end else if (in_accept) begin
         pass_left_ff    <= pass_left_in;
         gather_count_ff <= gather_count_in;
         gather_bytes_ff <= gather_bytes_in;
         held_valid_ff   <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         held_bytes_ff <= held_bytes_in;
      end
   end

endmodule

[rtl/cesu_burst.sv]
module cesu_burst
   import cesu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  burst_type  burst,
   output logic       can_load,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_byte,
   output logic       out_last
);

   logic [8*BURST_MAX-1:0] data_ff, data_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic                   take;

   assign out_valid = (count_ff != '0);
   assign out_byte  = data_ff[7:0];
   assign out_last  = (count_ff == COUNT_W'(1));
   assign take      = out_valid && out_ready;
   assign can_load  = !out_valid || (out_last && out_ready);

   always_comb begin
      data_in  = data_ff;
      count_in = count_ff;
      if (load) begin
         data_in  = burst.bytes;
         count_in = burst.count;
      end else if (take) begin
         data_in  = data_ff >> 8;
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

[rtl/cesu_checker.sv]
module cesu_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // stalled output transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled output transaction changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid straight after reset");

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input refused while output empty");

   a_no_accept_mid_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input accepted in the middle of a burst");

   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("burst ended without last");

endmodule

bind cesu8_to_utf8_converter cesu_checker u_cesu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench
   import cesu_pkg::*;
();

   localparam int DIRECTED_N   = 26;
   localparam int RANDOM_ITEMS = 304;
   localparam int STALL_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 20;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } utf8_beat_type;

   typedef struct packed {
      logic [7:0]  data;
      logic        eos;
      logic        typed_en;
      logic [1:0]  typed_n;
      logic [23:0] typed;     // first byte in the lowest bits
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   cesu8_to_utf8_converter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // converter state mirror
   logic [1:0]  cont_left;
   logic [1:0]  tri_count;
   logic [15:0] tri_bytes;
   logic        sur_pending;
   logic [23:0] sur_raw;

   logic [7:0]    burst_q[$];
   utf8_beat_type utf8_expected[$];

   int   errors;
   int   bytes_sent;
   int   bytes_seen;
   int   strings_ended;
   int   pairs_merged;
   int   random_sent;
   int   idle_cycles;
   logic calm;

   stim_row_type directed_rows [DIRECTED_N] = '{
      '{8'h00, 1'b0, 1'b1, 2'd1, 24'h000000},
      '{8'h7F, 1'b0, 1'b1, 2'd1, 24'h00007F},
      '{8'hC2, 1'b0, 1'b1, 2'd1, 24'h0000C2},
      '{8'hA9, 1'b0, 1'b1, 2'd1, 24'h0000A9},
      '{8'hF0, 1'b0, 1'b1, 2'd1, 24'h0000F0},
      '{8'h9F, 1'b0, 1'b1, 2'd1, 24'h00009F},
      '{8'h98, 1'b0, 1'b1, 2'd1, 24'h000098},
      '{8'h80, 1'b0, 1'b1, 2'd1, 24'h000080},
      // surrogate pair merges into one code point
      '{8'hED, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'hA0, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'hBD, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'hED, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'hB8, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'h80, 1'b0, 1'b0, 2'd0, 24'h000000},
      // two high surrogates, then unfinished triple at end of string
      '{8'hED, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'hAF, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'hBF, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'hED, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'hA0, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'h80, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'hE1, 1'b1, 1'b0, 2'd0, 24'h000000},
      '{8'hFF, 1'b1, 1'b1, 2'd1, 24'h0000FF},
      '{8'hE2, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'h82, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'hAC, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'hE0, 1'b1, 1'b1, 2'd1, 24'h0000E0}
   };

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic flush_surrogate();
      if (sur_pending) begin
         burst_q.push_back(sur_raw[23:16]);
         burst_q.push_back(sur_raw[15:8]);
         burst_q.push_back(sur_raw[7:0]);
         sur_pending = 1'b0;
      end
   endtask

   task automatic predict_utf8(input logic [7:0] b, input logic eos);
      logic [15:0] unit;
      logic [15:0] hs;
      logic [20:0] cp;
      burst_q.delete();
      if (cont_left != 2'd0) begin
         burst_q.push_back(b);
         cont_left = cont_left - 2'd1;
      end else if (tri_count == 2'd1) begin
         tri_bytes[7:0] = b;
         tri_count = 2'd2;
         if (eos) begin
            flush_surrogate();
            burst_q.push_back(tri_bytes[15:8]);
            burst_q.push_back(tri_bytes[7:0]);
         end
      end else if (tri_count != 2'd0) begin
         tri_count = 2'd0;
         unit = {tri_bytes[11:8], tri_bytes[5:0], b[5:0]};
         if (sur_pending && unit >= LOW_SUR_MIN && unit <= LOW_SUR_MAX) begin
            hs = {sur_raw[19:16], sur_raw[13:8], sur_raw[5:0]};
            cp = SUPP_BASE + {1'b0, hs[9:0], unit[9:0]};
            burst_q.push_back(LEAD4_MARK | {5'd0, cp[20:18]});
            burst_q.push_back(CONT_MARK | {2'd0, cp[17:12]});
            burst_q.push_back(CONT_MARK | {2'd0, cp[11:6]});
            burst_q.push_back(CONT_MARK | {2'd0, cp[5:0]});
            sur_pending = 1'b0;
            pairs_merged++;
         end else begin
            flush_surrogate();
            if (unit >= HIGH_SUR_MIN && unit <= HIGH_SUR_MAX) begin
               sur_raw = {tri_bytes, b};
               sur_pending = 1'b1;
            end else begin
               burst_q.push_back(tri_bytes[15:8]);
               burst_q.push_back(tri_bytes[7:0]);
               burst_q.push_back(b);
            end
         end
      end else if (b <= LEAD1_MAX) begin
         flush_surrogate();
         burst_q.push_back(b);
      end else if (b <= LEAD2_MAX) begin
         flush_surrogate();
         burst_q.push_back(b);
         cont_left = 2'd1;
      end else if (b <= LEAD3_MAX) begin
         tri_bytes = {b, 8'h00};
         tri_count = 2'd1;
         if (eos) begin
            flush_surrogate();
            burst_q.push_back(b);
         end
      end else begin
         flush_surrogate();
         burst_q.push_back(b);
         cont_left = 2'd3;
      end
      if (eos) begin
         flush_surrogate();
         cont_left   = 2'd0;
         tri_count   = 2'd0;
         tri_bytes   = 16'h0000;
         sur_pending = 1'b0;
         strings_ended++;
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic eos, input logic typed_en,
                            input logic [1:0] typed_n, input logic [23:0] typed);
      int i;
      while (!calm && $urandom_range(99) < 27) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_utf8(b, eos);
      if (typed_en) begin
         burst_q.delete();
         for (i = 0; i < typed_n; i++) burst_q.push_back(typed[8*i +: 8]);
      end
      for (i = 0; i < burst_q.size(); i++)
         utf8_expected.push_back('{burst_q[i], i == burst_q.size() - 1});
      bytes_sent++;
      @(negedge clock);
   endtask

   function automatic logic [7:0] cont_byte();
      if ($urandom_range(9) == 0) return 8'($urandom);
      return {2'b10, 6'($urandom)};
   endfunction

   // one random sequence, mostly well formed
   task automatic send_sequence();
      logic [7:0] seq[$];
      int kind;
      int cut;
      int i;
      int n;
      logic eos;
      kind = $urandom_range(99);
      if (kind < 20) begin
         seq.push_back({1'b0, 7'($urandom)});
      end else if (kind < 32) begin
         seq.push_back(8'($urandom_range(8'hDF, 8'hC0)));
         seq.push_back(cont_byte());
      end else if (kind < 45) begin
         seq.push_back(8'($urandom_range(8'hEF, 8'hE0)));
         seq.push_back(cont_byte());
         seq.push_back(cont_byte());
      end else if (kind < 65) begin
         seq.push_back(8'hED);
         seq.push_back(8'($urandom_range(8'hAF, 8'hA0)));
         seq.push_back(cont_byte());
         seq.push_back(8'hED);
         seq.push_back(8'($urandom_range(8'hBF, 8'hB0)));
         seq.push_back(cont_byte());
      end else if (kind < 73) begin
         seq.push_back(8'hED);
         seq.push_back(8'($urandom_range(8'hAF, 8'hA0)));
         seq.push_back(cont_byte());
      end else if (kind < 78) begin
         seq.push_back(8'hED);
         seq.push_back(8'($urandom_range(8'hBF, 8'hB0)));
         seq.push_back(cont_byte());
      end else if (kind < 88) begin
         seq.push_back(8'($urandom_range(8'hFF, 8'hF0)));
         seq.push_back(cont_byte());
         seq.push_back(cont_byte());
         seq.push_back(cont_byte());
      end else begin
         n = $urandom_range(3, 1);
         for (i = 0; i < n; i++) seq.push_back(8'($urandom));
      end
      cut = -1;
      if ($urandom_range(29) == 0) cut = $urandom_range(seq.size() - 1);
      else if ($urandom_range(7) == 0) cut = seq.size() - 1;
      for (i = 0; i < seq.size(); i++) begin
         if (cut >= 0 && i > cut) break;
         eos = (i == cut);
         send_byte(seq[i], eos, 1'b0, 2'd0, 24'h000000);
         random_sent++;
         calm = (random_sent >= 120 && random_sent < 200);
      end
   endtask

   always @(negedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 27);
   end

   always @(posedge clock) begin
      utf8_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         bytes_seen++;
         if (utf8_expected.size() == 0) begin
            $display("%0t: unexpected output byte %h last %b", $time, rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            want = utf8_expected.pop_front();
            if (rsp_tdata !== want.data) begin
               $display("%0t: out_byte expected %h actual %h", $time, want.data, rsp_tdata);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last_out expected %b actual %b", $time, want.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d bytes still expected",
                  $time, idle_cycles, utf8_expected.size());
         $display("testbench: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int i;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 8'h00;
      req_tlast     = 1'b0;
      calm          = 1'b0;
      cont_left     = 2'd0;
      tri_count     = 2'd0;
      tri_bytes     = 16'h0000;
      sur_pending   = 1'b0;
      sur_raw       = 24'h000000;
      errors        = 0;
      bytes_sent    = 0;
      bytes_seen    = 0;
      strings_ended = 0;
      pairs_merged  = 0;
      random_sent   = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (i = 0; i < DIRECTED_N; i++)
         send_byte(directed_rows[i].data, directed_rows[i].eos, directed_rows[i].typed_en,
                   directed_rows[i].typed_n, directed_rows[i].typed);
      while (random_sent < RANDOM_ITEMS) send_sequence();
      calm = 1'b0;
      req_tvalid <= 1'b0;

      while (utf8_expected.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d input bytes, %0d output bytes, %0d strings ended, %0d pairs merged",
               bytes_sent, bytes_seen, strings_ended, pairs_merged);
      if (errors == 0 && utf8_expected.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("%0d mismatches, %0d bytes never seen", errors, utf8_expected.size());
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
